### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define BPS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bps assertion failed");

// Next-cycle implication, disabled while in reset
`define BPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bps assertion failed");

// State in the cycle after any cycle with rst_n low
`define BPS_ASSERT_RESET(label, cons) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("bps reset assertion failed");

`endif

### rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Types, codes and constants shared by the bilinear pixel sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_FRAC_BITS  = 8;

  localparam int PIX_W      = 32;
  localparam int SIZE_W     = 9;   // size registers and clamped positions
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int MID_DEPTH  = 4;
  localparam int OUT_DEPTH  = 8;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [2:0] CH_COUNT_RGB = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } bps_cfg_idx_t;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  write_column;
    logic [7:0]  write_row;
    logic [31:0] write_word;
    logic [15:0] sample_x;
    logic [15:0] sample_y;
  } bps_in_t;

  typedef struct packed {
    logic [7:0] channel_3;
    logic [7:0] channel_2;
    logic [7:0] channel_1;
    logic [7:0] channel_0;
  } bps_out_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic              is_sample;
    logic              three_ch;
    logic              wr_en;
    logic [7:0]        wr_col;
    logic [7:0]        wr_row;
    logic [PIX_W-1:0]  wr_word;
    logic [SIZE_W-1:0] px;
    logic [SIZE_W-1:0] py;
    logic              has_right;
    logic              has_down;
    logic [15:0]       fx;
    logic [15:0]       fy;
  } bps_entry_t;

endpackage

`default_nettype wire

### rtl/bps_ram.sv
// ----------------------------------------------------------------------------
// bps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_ram import bps_pkg::*; #(
  parameter int WIDTH = PIX_W,
  parameter int DEPTH = (DEF_MAX_WIDTH / 2) * (DEF_MAX_HEIGHT / 2),
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

### rtl/bps_fifo.sv
// ----------------------------------------------------------------------------
// bps_fifo
// Small register-based queue with occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_fifo import bps_pkg::*; #(
  parameter int WIDTH = PIX_W,
  parameter int DEPTH = MID_DEPTH,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty,
  output logic      [CW-1:0]    count
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

### rtl/bps_front.sv
// ----------------------------------------------------------------------------
// bps_front
// Configuration registers and item classification: clamps sample
// positions, flags edge neighbours and qualifies pixel writes.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_front import bps_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire bps_in_t               in_data,
  output bps_entry_t                 entry
);

  localparam logic [SIZE_W-1:0] RST_W = SIZE_W'((MAX_WIDTH < 256) ? MAX_WIDTH : 256);
  localparam logic [SIZE_W-1:0] RST_H = SIZE_W'((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256);
  localparam logic [15:0] FMASK = 16'((33'd1 << FRAC_BITS) - 33'd1);

  // Sizes are held already clamped to 1 .. maximum
  logic [SIZE_W-1:0] eff_w_r, eff_w_nxt;
  logic [SIZE_W-1:0] eff_h_r, eff_h_nxt;
  logic              three_ch_r, three_ch_nxt;
  logic [SIZE_W-1:0] w_clamp, h_clamp;

  logic [15:0]       ix, iy;
  logic [SIZE_W-1:0] px, py;

  always_comb begin
    if (cfg_wdata == '0) begin
      w_clamp = SIZE_W'(1);
    end else if (32'(cfg_wdata) > MAX_WIDTH) begin
      w_clamp = SIZE_W'(MAX_WIDTH);
    end else begin
      w_clamp = SIZE_W'(cfg_wdata);
    end
    if (cfg_wdata == '0) begin
      h_clamp = SIZE_W'(1);
    end else if (32'(cfg_wdata) > MAX_HEIGHT) begin
      h_clamp = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_clamp = SIZE_W'(cfg_wdata);
    end

    eff_w_nxt    = eff_w_r;
    eff_h_nxt    = eff_h_r;
    three_ch_nxt = three_ch_r;
    if (cfg_we) begin
      case (bps_cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:   eff_w_nxt = w_clamp;
        CFG_IMAGE_HEIGHT:  eff_h_nxt = h_clamp;
        CFG_CHANNEL_COUNT: three_ch_nxt = (cfg_wdata[2:0] == CH_COUNT_RGB);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r    <= RST_W;
      eff_h_r    <= RST_H;
      three_ch_r <= 1'b0;
    end else begin
      eff_w_r    <= eff_w_nxt;
      eff_h_r    <= eff_h_nxt;
      three_ch_r <= three_ch_nxt;
    end
  end

  always_comb begin
    ix = in_data.sample_x >> FRAC_BITS;
    iy = in_data.sample_y >> FRAC_BITS;
    // clamp to the last column or row
    px = (32'(ix) >= 32'(eff_w_r)) ? eff_w_r - SIZE_W'(1) : SIZE_W'(ix);
    py = (32'(iy) >= 32'(eff_h_r)) ? eff_h_r - SIZE_W'(1) : SIZE_W'(iy);

    entry.is_sample = (in_data.opcode == OP_SAMPLE);
    entry.three_ch  = three_ch_r;
    entry.wr_en     = (32'(in_data.write_column) < MAX_WIDTH) &&
                      (32'(in_data.write_row) < MAX_HEIGHT);
    entry.wr_col    = in_data.write_column;
    entry.wr_row    = in_data.write_row;
    entry.wr_word   = in_data.write_word;
    entry.px        = px;
    entry.py        = py;
    entry.has_right = ({1'b0, px} + (SIZE_W+1)'(1)) < {1'b0, eff_w_r};
    entry.has_down  = ({1'b0, py} + (SIZE_W+1)'(1)) < {1'b0, eff_h_r};
    entry.fx        = in_data.sample_x & FMASK;
    entry.fy        = in_data.sample_y & FMASK;
  end

endmodule

`default_nettype wire

### rtl/bps_back.sv
// ----------------------------------------------------------------------------
// bps_back
// Parity-banked pixel store, weight and product pipeline, and the
// result queue. Issues one classified item per cycle if a sample has room.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_back import bps_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       head_valid,
  input  wire bps_entry_t head,
  output logic            head_pop,
  input  wire logic       out_pop,
  output logic            out_empty,
  output bps_out_t        out_data
);

  localparam int BANK_COLS  = (MAX_WIDTH + 1) / 2;
  localparam int BANK_ROWS  = (MAX_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int WTW        = 2 * FRAC_BITS + 1;
  localparam int PW         = 8 + WTW;
  localparam int ACCW       = PW + 2;
  localparam int OCW        = $clog2(OUT_DEPTH + 1);
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic            issue, room;
  logic [OCW-1:0]  out_count;

  logic [SIZE_W-1:0] pxh, pyh;
  logic [FRAC_BITS:0] fx, fy, fx1, fy1;
  logic [2*FRAC_BITS+1:0] wp0, wp1, wp2, wp3;

  logic [PIX_W-1:0] bank_q [4];

  // stage 1: RAM data and weights
  logic            s1_valid_r;
  logic            s1_px_r, s1_py_r, s1_hr_r, s1_hd_r, s1_three_r;
  logic [WTW-1:0]  s1_wt_r [4];

  // stage 2: channel products
  logic            s2_valid_r;
  logic            s2_three_r;
  logic [PW-1:0]   s2_prod_r [4][4];
  logic [PW-1:0]   prod_nxt [4][4];

  logic [PIX_W-1:0] q_base, q_right, q_down, q_diag;
  logic [PIX_W-1:0] pix [4];
  logic [ACCW-1:0]  acc [4];
  bps_out_t         res;

  // hold a sample back unless the result queue has a slot for it
  assign room     = (32'(out_count) + 32'(s1_valid_r) + 32'(s2_valid_r)) < OUT_DEPTH;
  assign issue    = head_valid && (!head.is_sample || room);
  assign head_pop = issue;

  assign pxh = head.px >> 1;
  assign pyh = head.py >> 1;

  genvar b;
  generate
    for (b = 0; b < 4; b++) begin : g_bank
      localparam logic BX = 1'(b % 2);
      localparam logic BY = 1'(b / 2);
      logic [SIZE_W-1:0]  ch, rh;
      logic [BANK_AW-1:0] raddr, waddr;
      logic               we;

      // an even bank takes the next half-position when the base is odd
      assign ch = BX ? pxh : pxh + SIZE_W'(head.px[0]);
      assign rh = BY ? pyh : pyh + SIZE_W'(head.py[0]);
      assign raddr = BANK_AW'(32'(rh) * BANK_COLS + 32'(ch));
      assign waddr = BANK_AW'(32'(head.wr_row[7:1]) * BANK_COLS + 32'(head.wr_col[7:1]));
      assign we = issue && !head.is_sample && head.wr_en &&
                  (head.wr_col[0] == BX) && (head.wr_row[0] == BY);

      bps_ram #(
        .WIDTH (PIX_W),
        .DEPTH (BANK_DEPTH)
      ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (head.wr_word),
        .raddr (raddr),
        .rdata (bank_q[b])
      );
    end
  endgenerate

  always_comb begin
    fx  = {1'b0, head.fx[FRAC_BITS-1:0]};
    fy  = {1'b0, head.fy[FRAC_BITS-1:0]};
    fx1 = ONE - fx;
    fy1 = ONE - fy;
    wp0 = fx1 * fy1;
    wp1 = fx * fy1;
    wp2 = fx1 * fy;
    wp3 = fx * fy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue && head.is_sample;
    end
  end

  always_ff @(posedge clk) begin
    s1_px_r    <= head.px[0];
    s1_py_r    <= head.py[0];
    s1_hr_r    <= head.has_right;
    s1_hd_r    <= head.has_down;
    s1_three_r <= head.three_ch;
    s1_wt_r[0] <= wp0[WTW-1:0];
    s1_wt_r[1] <= wp1[WTW-1:0];
    s1_wt_r[2] <= wp2[WTW-1:0];
    s1_wt_r[3] <= wp3[WTW-1:0];
  end

  // route bank outputs to base and neighbours by base parity
  always_comb begin
    case ({s1_py_r, s1_px_r})
      2'b00: begin
        q_base = bank_q[0]; q_right = bank_q[1]; q_down = bank_q[2]; q_diag = bank_q[3];
      end
      2'b01: begin
        q_base = bank_q[1]; q_right = bank_q[0]; q_down = bank_q[3]; q_diag = bank_q[2];
      end
      2'b10: begin
        q_base = bank_q[2]; q_right = bank_q[3]; q_down = bank_q[0]; q_diag = bank_q[1];
      end
      default: begin
        q_base = bank_q[3]; q_right = bank_q[2]; q_down = bank_q[1]; q_diag = bank_q[0];
      end
    endcase

    // replace neighbours past the edge by the base pixel
    pix[0] = q_base;
    pix[1] = s1_hr_r ? q_right : q_base;
    pix[2] = s1_hd_r ? q_down : q_base;
    pix[3] = (s1_hr_r && s1_hd_r) ? q_diag : q_base;

    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        prod_nxt[c][k] = pix[k][8*c +: 8] * s1_wt_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_three_r <= s1_three_r;
    s2_prod_r  <= prod_nxt;
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      acc[c] = ACCW'(s2_prod_r[c][0]) + ACCW'(s2_prod_r[c][1]) +
               ACCW'(s2_prod_r[c][2]) + ACCW'(s2_prod_r[c][3]);
    end
    res.channel_0 = acc[0][2*FRAC_BITS +: 8];
    res.channel_1 = acc[1][2*FRAC_BITS +: 8];
    res.channel_2 = acc[2][2*FRAC_BITS +: 8];
    res.channel_3 = s2_three_r ? 8'd0 : acc[3][2*FRAC_BITS +: 8];
  end

  bps_fifo #(
    .WIDTH ($bits(bps_out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (s2_valid_r),
    .wdata (res),
    .pop   (out_pop),
    .rdata (out_data),
    .full  (),
    .empty (out_empty),
    .count (out_count)
  );

endmodule

`default_nettype wire

### rtl/bilinear_pixel_sampler.sv
// ----------------------------------------------------------------------------
// bilinear_pixel_sampler
// Bilinear texture sampler over a stored image of packed pixel words.
// ----------------------------------------------------------------------------
// One item, write or sample, is taken per clock cycle while in_full is
// low. A sample result passes through the input queue, the bank reads
// and weights, the channel products and the result queue before it
// appears on the out_ ports; writes give no result. The rate comes from
// the pixel store being split into four banks by column and row parity,
// so the base pixel and its three neighbours are read together, one read
// port per bank. The store is not cleared after reset: a pixel must be
// written before it is sampled. Up to eight results are held for the
// consumer before the sampler stops taking samples, and a four-entry
// queue between the classifier and the banks absorbs stalls of the back end.
`default_nettype none

module bilinear_pixel_sampler import bps_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  input  wire bps_in_t               in_data,
  output logic                       in_full,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output bps_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  bps_entry_t entry, head;
  logic       mid_empty, head_pop;

  bps_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .entry     (entry)
  );

  bps_fifo #(
    .WIDTH ($bits(bps_entry_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (entry),
    .pop   (head_pop),
    .rdata (head),
    .full  (in_full),
    .empty (mid_empty),
    .count ()
  );

  bps_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (!mid_empty),
    .head       (head),
    .head_pop   (head_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

### rtl/bps_checker.sv
// ----------------------------------------------------------------------------
// bps_checker
// Port-level assertions for the bilinear pixel sampler, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bps_checker import bps_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_push,
  input wire logic                  in_full,
  input wire logic                  out_empty,
  input wire logic                  out_pop,
  input wire bps_out_t              out_data,
  input wire logic                  cfg_we,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // track the channel count as last written
  logic three_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      three_r <= 1'b0;
    end else if (cfg_we && (cfg_index == CFG_CHANNEL_COUNT)) begin
      three_r <= (cfg_wdata[2:0] == CH_COUNT_RGB);
    end
  end

  `BPS_ASSERT_RESET(a_reset_empty, out_empty && !in_full)
  `BPS_ASSERT_NEXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_data))
  `BPS_ASSERT_SAME(a_full_by_push, $rose(in_full), $past(in_push))
  `BPS_ASSERT_SAME(a_rgb_alpha_zero, !out_empty && three_r, out_data.channel_3 == 8'd0)

endmodule

bind bilinear_pixel_sampler bps_checker u_bps_checker (.*);

`default_nettype wire
